// ----- hdl/assert_macros.svh -----
// Assertion macros used by the checker file of the vertex weld table.
// No dependencies; include this file by its bare name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("same-cycle implication failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("next-cycle implication failed");

`endif

// ----- hdl/vwt_pkg.sv -----
// Types and constants of the vertex weld table: beat structs, command codes,
// register map and field widths. No dependencies.
package vwt_pkg;

    // Field widths fixed by the interface.
    localparam int COORD_W    = 16;
    localparam int COLOR_W    = 32;
    localparam int LIMIT_W    = 34;
    localparam int IDX_W      = 8;
    localparam int CNT_W      = 9;
    localparam int APB_DATA_W = 64;
    localparam int APB_ADDR_W = 4;

    // Pipeline depth of the distance unit.
    localparam int DIST_LATENCY = 3;

    // Command codes.
    typedef logic [1:0] t_cmd;
    localparam t_cmd CMD_APPEND = 2'd0;
    localparam t_cmd CMD_CLEAR  = 2'd1;
    localparam t_cmd CMD_READ   = 2'd2;
    localparam t_cmd CMD_NOP    = 2'd3;

    // Register index, taken from paddr bit 3 (registers are 8 bytes apart).
    localparam logic REG_WELD_LIMIT = 1'b0;
    localparam logic [LIMIT_W-1:0] WELD_LIMIT_RST = 34'd1;

    // Input beat.
    typedef struct packed {
        t_cmd                       cmd;
        logic signed [COORD_W-1:0]  x_coord;
        logic signed [COORD_W-1:0]  y_coord;
        logic [COLOR_W-1:0]         vertex_color;
        logic [IDX_W-1:0]           read_index;
    } t_in_beat;

    // Output beat.
    typedef struct packed {
        logic [IDX_W-1:0]           vertex_index;
        logic                       is_new;
        logic                       table_full;
        logic signed [COORD_W-1:0]  out_x;
        logic signed [COORD_W-1:0]  out_y;
        logic [COLOR_W-1:0]         out_color;
        logic [CNT_W-1:0]           entry_count;
    } t_out_beat;

    // One stored vertex.
    typedef struct packed {
        logic [COLOR_W-1:0]         color;
        logic signed [COORD_W-1:0]  y;
        logic signed [COORD_W-1:0]  x;
    } t_vertex;

    // Control of one ring cell.
    typedef struct packed {
        logic shift;
        logic load;
    } t_cell_ctl;

endpackage

// ----- hdl/vwt_cell.sv -----
// One cell of the vertex ring: holds one stored vertex and takes its
// neighbor's vertex, or a new one, on every shift. Depends on vwt_pkg.
module vwt_cell (
    input  logic                i_clk,
    input  vwt_pkg::t_cell_ctl  i_ctl,
    input  vwt_pkg::t_vertex    i_next,
    input  vwt_pkg::t_vertex    i_load_data,
    output vwt_pkg::t_vertex    o_vertex
);

    vwt_pkg::t_vertex r_vertex;

    // Shift from the neighbor, or take the new vertex when loading.
    always_ff @(posedge i_clk) begin
        if (i_ctl.shift) begin
            r_vertex <= i_ctl.load ? i_load_data : i_next;
        end
    end

    assign o_vertex = r_vertex;

endmodule

// ----- hdl/vwt_dist.sv -----
// Three-stage squared-distance compare of one stored vertex against the
// query point, with a tag that follows each beat. Depends on vwt_pkg.
module vwt_dist #(
    parameter int TAG_W = 8
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    input  logic [TAG_W-1:0]                    i_tag,
    input  logic signed [vwt_pkg::COORD_W-1:0]  i_qx,
    input  logic signed [vwt_pkg::COORD_W-1:0]  i_qy,
    input  vwt_pkg::t_vertex                    i_vertex,
    input  logic [vwt_pkg::LIMIT_W-1:0]         i_limit,
    output logic                                o_hit,
    output logic [TAG_W-1:0]                    o_tag
);

    localparam int CW  = vwt_pkg::COORD_W;
    localparam int SQW = 2 * CW;

    logic [CW:0]     w_dx;
    logic [CW:0]     w_dy;
    logic [CW:0]     w_adx;
    logic [CW:0]     w_ady;
    logic [SQW-1:0]  w_sqx;
    logic [SQW-1:0]  w_sqy;
    logic [SQW:0]    w_sum;

    logic            r_v1;
    logic            r_v2;
    logic [TAG_W-1:0] r_tag1;
    logic [TAG_W-1:0] r_tag2;
    logic [CW-1:0]   r_ax;
    logic [CW-1:0]   r_ay;
    logic [SQW-1:0]  r_sqx;
    logic [SQW-1:0]  r_sqy;
    logic            r_hit;
    logic [TAG_W-1:0] r_tag3;

    // Stage one: sign-extended differences and their magnitudes.
    assign w_dx  = {i_vertex.x[CW-1], i_vertex.x} - {i_qx[CW-1], i_qx};
    assign w_dy  = {i_vertex.y[CW-1], i_vertex.y} - {i_qy[CW-1], i_qy};
    assign w_adx = w_dx[CW] ? (~w_dx + 1'b1) : w_dx;
    assign w_ady = w_dy[CW] ? (~w_dy + 1'b1) : w_dy;

    // Stage two: squares.
    assign w_sqx = r_ax * r_ax;
    assign w_sqy = r_ay * r_ay;

    // Stage three: sum and threshold compare.
    assign w_sum = {1'b0, r_sqx} + {1'b0, r_sqy};

    // Valid bits of the pipeline.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1  <= 1'b0;
            r_v2  <= 1'b0;
            r_hit <= 1'b0;
        end else begin
            r_v1  <= i_valid;
            r_v2  <= r_v1;
            r_hit <= r_v2 && ({1'b0, w_sum} < i_limit);
        end
    end

    // Payload of the pipeline.
    always_ff @(posedge i_clk) begin
        r_ax   <= w_adx[CW-1:0];
        r_ay   <= w_ady[CW-1:0];
        r_tag1 <= i_tag;
        r_sqx  <= w_sqx;
        r_sqy  <= w_sqy;
        r_tag2 <= r_tag1;
        r_tag3 <= r_tag2;
    end

    assign o_hit = r_hit;
    assign o_tag = r_tag3;

endmodule

// ----- hdl/vertex_weld_table.sv -----
// Append and read scan one full turn of the vertex ring past the single distance unit
// (ST_SCAN), drain its three-stage pipeline (ST_DRAIN) and register the result beat in
// ST_FINISH, which waits while the output is stalled. A new beat is taken only after
// that, back in ST_IDLE. Clear and the unused command go straight to ST_FINISH.
// Reset empties the table (count zero) and sets weld_limit to 1; the ring cells
// are not cleared and hold stale vertices until written.
module vertex_weld_table #(
    parameter int MAX_VERTICES = 256
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  vwt_pkg::t_in_beat                   i_in_data,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output vwt_pkg::t_out_beat                  o_out_data,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [vwt_pkg::APB_ADDR_W-1:0]      paddr,
    input  logic [vwt_pkg::APB_DATA_W-1:0]      pwdata,
    output logic [vwt_pkg::APB_DATA_W-1:0]      prdata,
    output logic                                pready
);

    localparam int IW   = $clog2(MAX_VERTICES);
    localparam int CW   = $clog2(MAX_VERTICES + 1);
    localparam int RIW  = IW + vwt_pkg::IDX_W;
    localparam int RCW  = CW + vwt_pkg::IDX_W;
    localparam logic [IW-1:0] LAST_IDX = IW'(MAX_VERTICES - 1);
    localparam logic [CW-1:0] MAX_CNT  = CW'(MAX_VERTICES);
    localparam logic [1:0]    LAST_DRAIN = 2'(vwt_pkg::DIST_LATENCY - 1);

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_SCAN   = 4'b0010,
        ST_DRAIN  = 4'b0100,
        ST_FINISH = 4'b1000
    } t_state;

    t_state                             r_state;
    t_state                             n_state;
    logic [IW-1:0]                      r_idx;
    logic [1:0]                         r_drain;
    logic [CW-1:0]                      r_count;
    logic [vwt_pkg::LIMIT_W-1:0]        r_limit;
    vwt_pkg::t_cmd                      r_cmd;
    vwt_pkg::t_vertex                   r_query;
    logic [vwt_pkg::IDX_W-1:0]          r_rd_idx;
    logic                               r_found;
    logic [IW-1:0]                      r_hit_idx;
    vwt_pkg::t_vertex                   r_rd_vertex;
    logic                               r_out_valid;
    vwt_pkg::t_out_beat                 r_out;

    logic                               w_in_acc;
    logic                               w_out_free;
    logic                               w_scan;
    logic                               w_tag_valid;
    logic                               w_tail_load;
    logic                               w_rd_here;
    logic                               w_rd_valid;
    logic                               w_hit;
    logic [IW-1:0]                      w_hit_idx;
    logic                               w_cfg_wr;
    logic                               w_append_new;
    vwt_pkg::t_out_beat                 w_res;
    vwt_pkg::t_vertex                   w_cell [MAX_VERTICES];
    vwt_pkg::t_vertex                   w_new_vertex;
    vwt_pkg::t_cell_ctl                 w_ctl_body;
    vwt_pkg::t_cell_ctl                 w_ctl_tail;

    assign w_in_acc   = i_in_valid && o_in_ready;
    assign w_out_free = !r_out_valid || i_out_ready;
    assign w_scan     = (r_state == ST_SCAN);

    // Ring control: all cells shift during a scan; the tail cell takes the
    // new vertex when the free slot passes the head.
    assign w_tail_load = w_scan && (r_cmd == vwt_pkg::CMD_APPEND)
                         && (CW'(r_idx) == r_count) && (r_count < MAX_CNT);
    assign w_ctl_body  = '{shift: w_scan, load: 1'b0};
    assign w_ctl_tail  = '{shift: w_scan, load: w_tail_load};
    assign w_new_vertex = r_query;

    // The ring of vertex cells; cell zero is the head seen by the distance unit.
    for (genvar k = 0; k < MAX_VERTICES; k++) begin : g_ring
        if (k == MAX_VERTICES - 1) begin : g_tail
            vwt_cell u_cell (
                .i_clk       (i_clk),
                .i_ctl       (w_ctl_tail),
                .i_next      (w_cell[0]),
                .i_load_data (w_new_vertex),
                .o_vertex    (w_cell[k])
            );
        end else begin : g_body
            vwt_cell u_cell (
                .i_clk       (i_clk),
                .i_ctl       (w_ctl_body),
                .i_next      (w_cell[k+1]),
                .i_load_data (w_new_vertex),
                .o_vertex    (w_cell[k])
            );
        end
    end

    // Distance unit on the head cell, fed only with valid entries of an append.
    assign w_tag_valid = w_scan && (r_cmd == vwt_pkg::CMD_APPEND)
                         && (CW'(r_idx) < r_count);

    vwt_dist #(
        .TAG_W (IW)
    ) u_dist (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (w_tag_valid),
        .i_tag    (r_idx),
        .i_qx     (r_query.x),
        .i_qy     (r_query.y),
        .i_vertex (w_cell[0]),
        .i_limit  (r_limit),
        .o_hit    (w_hit),
        .o_tag    (w_hit_idx)
    );

    // Readout capture when the requested entry reaches the head.
    assign w_rd_here  = w_scan && (r_cmd == vwt_pkg::CMD_READ)
                        && (RIW'(r_rd_idx) == RIW'(r_idx));
    assign w_rd_valid = (RCW'(r_rd_idx) < RCW'(r_count));

    // Sequencer.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_in_acc) begin
                    if (i_in_data.cmd == vwt_pkg::CMD_APPEND ||
                        i_in_data.cmd == vwt_pkg::CMD_READ) begin
                        n_state = ST_SCAN;
                    end else begin
                        n_state = ST_FINISH;
                    end
                end
            end
            ST_SCAN: begin
                if (r_idx == LAST_IDX) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (r_drain == LAST_DRAIN) begin
                    n_state = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    assign w_append_new = (r_cmd == vwt_pkg::CMD_APPEND) && !r_found && (r_count < MAX_CNT);

    // Result of the finished item.
    always_comb begin
        w_res             = '0;
        w_res.entry_count = vwt_pkg::CNT_W'(r_count);
        case (r_cmd) inside
            vwt_pkg::CMD_APPEND: begin
                if (r_found) begin
                    w_res.vertex_index = vwt_pkg::IDX_W'(r_hit_idx);
                end else if (r_count < MAX_CNT) begin
                    w_res.vertex_index = vwt_pkg::IDX_W'(r_count);
                    w_res.is_new       = 1'b1;
                    w_res.entry_count  = vwt_pkg::CNT_W'(r_count + CW'(1));
                end else begin
                    w_res.table_full   = 1'b1;
                end
            end
            vwt_pkg::CMD_READ: begin
                w_res.vertex_index = r_rd_idx;
                w_res.out_x        = r_rd_vertex.x;
                w_res.out_y        = r_rd_vertex.y;
                w_res.out_color    = r_rd_vertex.color;
            end
            vwt_pkg::CMD_CLEAR,
            vwt_pkg::CMD_NOP: begin
                w_res.vertex_index = '0;
            end
            default: begin
                w_res.vertex_index = '0;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_idx       <= '0;
            r_drain     <= '0;
            r_count     <= '0;
            r_found     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_in_acc) begin
                r_idx   <= '0;
                r_drain <= '0;
                r_found <= 1'b0;
                if (i_in_data.cmd == vwt_pkg::CMD_CLEAR) begin
                    r_count <= '0;
                end
            end
            if (w_scan) begin
                r_idx <= (r_idx == LAST_IDX) ? '0 : r_idx + 1'b1;
            end
            if (r_state == ST_DRAIN) begin
                r_drain <= r_drain + 1'b1;
            end
            if (w_hit && !r_found) begin
                r_found <= 1'b1;
            end
            if (r_state == ST_FINISH && w_out_free) begin
                r_out_valid <= 1'b1;
                if (w_append_new) begin
                    r_count <= r_count + CW'(1);
                end
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers of the current item and the result beat.
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_cmd         <= i_in_data.cmd;
            r_query.x     <= i_in_data.x_coord;
            r_query.y     <= i_in_data.y_coord;
            r_query.color <= i_in_data.vertex_color;
            r_rd_idx      <= i_in_data.read_index;
            r_rd_vertex   <= '0;
        end
        if (w_hit && !r_found) begin
            r_hit_idx <= w_hit_idx;
        end
        if (w_rd_here && w_rd_valid) begin
            r_rd_vertex <= w_cell[0];
        end
        if (r_state == ST_FINISH && w_out_free) begin
            r_out <= w_res;
        end
    end

    // Configuration port.
    assign w_cfg_wr = psel && penable && pwrite && pready
                      && (paddr[3] == vwt_pkg::REG_WELD_LIMIT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= vwt_pkg::WELD_LIMIT_RST;
        end else if (w_cfg_wr) begin
            r_limit <= pwdata[vwt_pkg::LIMIT_W-1:0];
        end
    end

    assign prdata = (paddr[3] == vwt_pkg::REG_WELD_LIMIT)
                    ? vwt_pkg::APB_DATA_W'(r_limit) : '0;
    assign pready = 1'b1;

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

// ----- hdl/vwt_checker.sv -----
// Port-level checks of the vertex weld table, bound to the top level.
// Depends on vwt_pkg and assert_macros.svh.
`include "assert_macros.svh"

module vwt_checker (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_in_valid,
    input logic                 o_in_ready,
    input logic                 o_out_valid,
    input logic                 i_out_ready,
    input vwt_pkg::t_out_beat   o_out_data
);

    // A full-table miss stores nothing and reports index zero.
    `ASSERT_IMPL(a_full_miss, i_clk, i_rst_n, o_out_valid && o_out_data.table_full, !o_out_data.is_new && o_out_data.vertex_index == '0 && o_out_data.entry_count != '0)

    // A new vertex always lands at the last occupied slot.
    `ASSERT_IMPL(a_new_last, i_clk, i_rst_n, o_out_valid && o_out_data.is_new, o_out_data.vertex_index == o_out_data.entry_count[7:0] - 8'd1)

    // The block works on one item at a time.
    `ASSERT_NEXT(a_one_item, i_clk, i_rst_n, i_in_valid && o_in_ready, !o_in_ready)

    // A stalled result beat holds.
    `ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid && $stable(o_out_data))

endmodule

bind vertex_weld_table vwt_checker u_vwt_checker (.*);
